FILE: sv/qsef_pkg.sv
// Shared types and constants for the quoted string end finder.
// Used by qsef_scan, quoted_string_end_finder and qsef_checker; depends on nothing.
package qsef_pkg;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 16;
  localparam int OFFSET_W    = 16;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int MAX_WINDOW  = 65536;

  // offset at which a window is cut short when no last byte has come
  localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(MAX_WINDOW - 1);

  localparam logic [BYTE_W-1:0] QUOTE_RESET  = 8'd34;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd92;

  // register index, taken from paddr[2]
  localparam logic REG_QUOTE  = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] quote_char;
    logic [BYTE_W-1:0] escape_char;
  } cfg_t;

  typedef struct packed {
    logic             emit;
    logic             found;
    logic [POS_W-1:0] position;
  } scan_result_t;

endpackage

FILE: sv/qsef_scan.sv
// Per-byte window scanner: escape parity, doubled-quote tracking and offset count.
// Depends on qsef_pkg for widths, the configuration struct and the result struct.
module qsef_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [qsef_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         last_byte,
  input  qsef_pkg::cfg_t               cfg,
  output qsef_pkg::scan_result_t       result
);

  logic [qsef_pkg::OFFSET_W-1:0] byte_offset;
  logic [qsef_pkg::OFFSET_W-1:0] byte_offset_next;
  logic                          escape_parity;
  logic                          escape_parity_next;
  logic                          pending_quote;
  logic                          pending_quote_next;
  logic                          window_done;
  logic                          window_done_next;

  logic                          eff_last;
  logic                          is_quote;
  logic                          doubled;
  logic                          hit;
  logic [qsef_pkg::OFFSET_W-1:0] hit_pos;

  assign eff_last = last_byte || (byte_offset == qsef_pkg::LAST_OFFSET);
  assign is_quote = (data_byte == cfg.quote_char);
  assign doubled  = (cfg.quote_char == cfg.escape_char);

  always_comb begin
    result             = '0;
    hit                = 1'b0;
    hit_pos            = byte_offset;
    byte_offset_next   = byte_offset;
    escape_parity_next = escape_parity;
    pending_quote_next = pending_quote;
    window_done_next   = window_done;

    if (step && !window_done) begin
      if (doubled) begin
        if (pending_quote) begin
          pending_quote_next = 1'b0;
          if (!is_quote) begin
            // previous byte was the closing quote
            result.emit = 1'b1;
            hit         = 1'b1;
            hit_pos     = byte_offset - qsef_pkg::OFFSET_W'(1);
          end else if (eff_last) begin
            result.emit = 1'b1;
          end
        end else if (is_quote) begin
          if (eff_last) begin
            result.emit = 1'b1;
            hit         = 1'b1;
          end else begin
            pending_quote_next = 1'b1;
          end
        end else if (eff_last) begin
          result.emit = 1'b1;
        end
      end else begin
        if (is_quote) begin
          if (!escape_parity) begin
            result.emit = 1'b1;
            hit         = 1'b1;
          end else begin
            escape_parity_next = 1'b0;
          end
        end else if (data_byte == cfg.escape_char) begin
          escape_parity_next = ~escape_parity;
        end else begin
          escape_parity_next = 1'b0;
        end
        if (eff_last) begin
          result.emit = 1'b1;
        end
      end
      byte_offset_next = byte_offset + qsef_pkg::OFFSET_W'(1);
      window_done_next = result.emit;
    end

    result.found    = hit;
    result.position = hit ? qsef_pkg::POS_W'(hit_pos) : '0;

    // the marked last byte always starts a fresh window
    if (step && last_byte) begin
      byte_offset_next   = '0;
      escape_parity_next = 1'b0;
      pending_quote_next = 1'b0;
      window_done_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      escape_parity <= 1'b0;
      pending_quote <= 1'b0;
      window_done   <= 1'b0;
    end else begin
      byte_offset   <= byte_offset_next;
      escape_parity <= escape_parity_next;
      pending_quote <= pending_quote_next;
      window_done   <= window_done_next;
    end
  end

endmodule

FILE: sv/quoted_string_end_finder.sv
// Top level of the quoted string end finder: APB registers, input register, result buffer.
// Depends on qsef_pkg and instantiates qsef_scan.
//
// Usage: feed the bytes that follow an opening quote on the input channel
// (data_byte, last_byte) with in_valid/in_stall; mark the final byte of each
// window with last_byte. One result per window comes out on the output
// channel (found, position, result_last) with out_valid/out_stall, at the
// byte that decides it; bytes after that up to last_byte give no result.
// quote_char sits at address 0, escape_char at address 4; writing the same
// value to both selects doubled-quote mode.
// Throughput: one byte per cycle while in_stall is low. A deciding byte passes the
// input register, then its result is registered in the result register.
// When the receiver stalls, the result holds and a two-entry result buffer
// keeps taking results; once both entries are full the scanner holds, and
// in_stall rises as soon as the input register also holds a byte.
// Reset loads quote 34 and escape 92, starts a fresh window and empties all
// buffers.
module quoted_string_end_finder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [qsef_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [qsef_pkg::POS_W-1:0]    position,
  output logic                          result_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qsef_pkg::ADDR_W-1:0]   paddr,
  input  logic [qsef_pkg::DATA_W-1:0]   pwdata,
  output logic [qsef_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  qsef_pkg::cfg_t cfg;

  logic                        s1_valid;
  logic [qsef_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_last;
  logic                        s1_adv;
  logic                        in_accept;

  qsef_pkg::scan_result_t      res;
  logic                        push;
  logic                        out_take;

  logic                        skid_valid;
  logic                        skid_found;
  logic [qsef_pkg::POS_W-1:0]  skid_position;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quote_char  <= qsef_pkg::QUOTE_RESET;
      cfg.escape_char <= qsef_pkg::ESCAPE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        qsef_pkg::REG_QUOTE:  cfg.quote_char  <= pwdata[qsef_pkg::BYTE_W-1:0];
        qsef_pkg::REG_ESCAPE: cfg.escape_char <= pwdata[qsef_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      qsef_pkg::REG_QUOTE:
        prdata = {{(qsef_pkg::DATA_W - qsef_pkg::BYTE_W){1'b0}}, cfg.quote_char};
      qsef_pkg::REG_ESCAPE:
        prdata = {{(qsef_pkg::DATA_W - qsef_pkg::BYTE_W){1'b0}}, cfg.escape_char};
      default: prdata = '0;
    endcase
  end

  // input register: advance whenever the result buffer has a free entry
  assign s1_adv    = s1_valid && !skid_valid;
  assign in_stall  = s1_valid && skid_valid;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  qsef_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .cfg       (cfg),
    .result    (res)
  );

  // two-entry result buffer: output register plus skid entry
  assign push     = s1_adv && res.emit;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        found    <= skid_found;
        position <= skid_position;
      end else begin
        found    <= res.found;
        position <= res.position;
      end
    end else if (push) begin
      skid_found    <= res.found;
      skid_position <= res.position;
    end
  end

  assign result_last = 1'b1;

endmodule

FILE: sv/qsef_checker.sv
// Port-level checker for quoted_string_end_finder, attached by the bind below.
// Depends on qsef_pkg for port widths.
module qsef_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         found,
  input  logic [qsef_pkg::POS_W-1:0]   position,
  input  logic                         result_last,
  input  logic                         pready
);

  // a miss reports offset zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (position == '0))
    else $error("miss result with nonzero position");

  // every result closes its window
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_last)
    else $error("result without result_last");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(found) && $stable(position)))
    else $error("stalled result changed");

  // nothing pending and nothing stalled right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !in_stall && pready))
    else $error("buffers not empty after reset");

endmodule

bind quoted_string_end_finder qsef_checker u_qsef_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .found       (found),
  .position    (position),
  .result_last (result_last),
  .pready      (pready)
);

FILE: tb/quoted_string_end_finder_test.sv
// Testbench for quoted_string_end_finder: directed and random byte windows, scored against
// a cycle-free predictor of the closing-quote search. Depends on qsef_pkg and the RTL only.
`timescale 1ns / 1ps

module quoted_string_end_finder_test;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_LIMIT   = 10000;

  typedef struct packed {
    logic                       found;
    logic [qsef_pkg::POS_W-1:0] position;
    logic                       result_last;
  } string_end_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [qsef_pkg::BYTE_W-1:0]   data_byte;
  logic                          last_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic                          found;
  logic [qsef_pkg::POS_W-1:0]    position;
  logic                          result_last;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [qsef_pkg::ADDR_W-1:0]   paddr;
  logic [qsef_pkg::DATA_W-1:0]   pwdata;
  logic [qsef_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // predictor state
  logic [qsef_pkg::BYTE_W-1:0]   cfg_quote  = qsef_pkg::QUOTE_RESET;
  logic [qsef_pkg::BYTE_W-1:0]   cfg_escape = qsef_pkg::ESCAPE_RESET;
  int unsigned                   win_offset = 0;
  logic                          esc_odd    = 1'b0;
  logic                          quote_held = 1'b0;
  logic                          win_closed = 1'b0;
  string_end_t                   expected_ends[$];

  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_request   = 1'b0;
  int                  bytes_sent     = 0;
  int                  mismatches     = 0;
  int                  quiet_cycles   = 0;

  quoted_string_end_finder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .position(position), .result_last(result_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Advance the closing-quote search by one accepted byte.
  function automatic void track_byte(input logic [qsef_pkg::BYTE_W-1:0] b, input logic l);
    logic        eff_last;
    logic        is_quote;
    logic        decided;
    logic        hit;
    int unsigned pos;
    string_end_t res;
    decided = 1'b0;
    hit     = 1'b0;
    pos     = 0;
    if (!win_closed) begin
      eff_last = l || (win_offset >= qsef_pkg::MAX_WINDOW - 1);
      is_quote = (b == cfg_quote);
      if (cfg_quote == cfg_escape) begin
        if (quote_held) begin
          quote_held = 1'b0;
          if (!is_quote) begin
            decided = 1'b1;
            hit     = 1'b1;
            pos     = win_offset - 1;
          end else if (eff_last) begin
            decided = 1'b1;
          end
        end else if (is_quote) begin
          if (eff_last) begin
            decided = 1'b1;
            hit     = 1'b1;
            pos     = win_offset;
          end else begin
            quote_held = 1'b1;
          end
        end else if (eff_last) begin
          decided = 1'b1;
        end
      end else begin
        if (is_quote) begin
          if (!esc_odd) begin
            decided = 1'b1;
            hit     = 1'b1;
            pos     = win_offset;
          end else begin
            esc_odd = 1'b0;
          end
        end else if (b == cfg_escape) begin
          esc_odd = !esc_odd;
        end else begin
          esc_odd = 1'b0;
        end
        if (!decided && eff_last) decided = 1'b1;
      end
      win_offset++;
      if (decided) begin
        win_closed      = 1'b1;
        res.found       = hit;
        res.position    = hit ? pos[qsef_pkg::POS_W-1:0] : '0;
        res.result_last = 1'b1;
        expected_ends.push_back(res);
      end
    end
    if (l) begin
      win_offset = 0;
      esc_odd    = 1'b0;
      quote_held = 1'b0;
      win_closed = 1'b0;
    end
  endfunction

  task automatic send_byte(input logic [qsef_pkg::BYTE_W-1:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
    track_byte(b, l);
    bytes_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline run dry.
  task automatic settle_results();
    in_valid <= 1'b0;
    while (expected_ends.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [qsef_pkg::BYTE_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == qsef_pkg::REG_QUOTE) cfg_quote = val;
    else cfg_escape = val;
  endtask

  task automatic send_window(input int len, input bit noisy);
    logic [qsef_pkg::BYTE_W-1:0] b;
    int                          r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (noisy || r >= 50) b = 8'($urandom_range(255));
      else if (r < 30) b = cfg_quote;
      else b = cfg_escape;
      send_byte(b, i == len - 1);
    end
  endtask

  // Reset config: plain close, escaped quotes, no quote, quote as only byte.
  task automatic test_escape_mode();
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(cfg_quote, 1'b0);
    send_byte(8'h7a, 1'b1);
    send_byte(cfg_escape, 1'b0);
    send_byte(cfg_quote, 1'b0);
    send_byte(cfg_escape, 1'b0);
    send_byte(cfg_escape, 1'b0);
    send_byte(cfg_quote, 1'b0);
    send_byte(8'h71, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(cfg_quote, 1'b1);
  endtask

  // Doubled-quote mode at the top of the byte range.
  task automatic test_doubled_mode();
    settle_results();
    write_reg(qsef_pkg::REG_QUOTE, 8'hff);
    write_reg(qsef_pkg::REG_ESCAPE, 8'hff);
    send_byte(cfg_quote, 1'b0);
    send_byte(cfg_quote, 1'b0);
    send_byte(cfg_quote, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(cfg_quote, 1'b0);
    send_byte(cfg_quote, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(cfg_quote, 1'b1);
  endtask

  // Switch to doubled mode in the middle of a window; window state carries over.
  task automatic test_midwindow_config();
    settle_results();
    write_reg(qsef_pkg::REG_QUOTE, 8'h00);
    write_reg(qsef_pkg::REG_ESCAPE, 8'hff);
    send_byte(cfg_escape, 1'b0);
    settle_results();
    write_reg(qsef_pkg::REG_ESCAPE, 8'h00);
    send_byte(cfg_quote, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  // Windows past MAX_WINDOW: search cut at the last allowed offset.
  task automatic test_long_windows();
    settle_results();
    write_reg(qsef_pkg::REG_QUOTE, qsef_pkg::QUOTE_RESET);
    write_reg(qsef_pkg::REG_ESCAPE, qsef_pkg::ESCAPE_RESET);
    for (int i = 0; i < qsef_pkg::MAX_WINDOW + 4; i++)
      send_byte((i == qsef_pkg::MAX_WINDOW - 1) ? cfg_quote : 8'h61,
                i == qsef_pkg::MAX_WINDOW + 3);
    settle_results();
    write_reg(qsef_pkg::REG_ESCAPE, cfg_quote);
    for (int i = 0; i < qsef_pkg::MAX_WINDOW + 1; i++)
      send_byte(8'h62, i == qsef_pkg::MAX_WINDOW);
  endtask

  // Hold the receiver off while short windows keep coming, then drain completely.
  task automatic test_backpressure();
    settle_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (30) begin
      send_byte(cfg_quote, 1'b0);
      send_byte(8'h20, 1'b1);
    end
    settle_results();
  endtask

  task automatic test_random_windows(input int send_pct, input int recv_pct, input int budget,
                                     input bit doubled);
    logic [qsef_pkg::BYTE_W-1:0] q;
    logic [qsef_pkg::BYTE_W-1:0] e;
    int                          stop_at;
    int                          len;
    settle_results();
    q = 8'($urandom_range(255));
    e = doubled ? q : 8'($urandom_range(255));
    if (!doubled && e == q) e = ~q;
    write_reg(qsef_pkg::REG_QUOTE, q);
    write_reg(qsef_pkg::REG_ESCAPE, e);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
      send_window(len, $urandom_range(4) == 0);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // score each result transaction against the oldest expectation
  always @(posedge clk) begin
    string_end_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ends.size() == 0) begin
        $display("%0t: unexpected result found=%0b position=%0d result_last=%0b",
                 $time, found, position, result_last);
        mismatches++;
      end else begin
        want = expected_ends.pop_front();
        if (found !== want.found) begin
          $display("%0t: found expected %0b got %0b", $time, want.found, found);
          mismatches++;
        end
        if (position !== want.position) begin
          $display("%0t: position expected %0d got %0d", $time, want.position, position);
          mismatches++;
        end
        if (result_last !== want.result_last) begin
          $display("%0t: result_last expected %0b got %0b", $time, want.result_last,
                   result_last);
          mismatches++;
        end
      end
    end
  end

  // watchdog: stop when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_escape_mode();
    test_doubled_mode();
    test_midwindow_config();
    test_long_windows();
    test_backpressure();
    test_random_windows(0, 0, 180, 1'b0);
    test_random_windows(0, 0, 180, 1'b1);
    test_random_windows(65, 0, 180, 1'b0);
    test_random_windows(65, 0, 180, 1'b1);
    test_random_windows(0, 65, 180, 1'b0);
    test_random_windows(0, 65, 180, 1'b1);
    test_random_windows(35, 35, 180, 1'b0);
    test_random_windows(35, 35, 180, 1'b1);
    settle_results();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/qsef_pkg.sv
sv/qsef_scan.sv
sv/quoted_string_end_finder.sv
sv/qsef_checker.sv
tb/quoted_string_end_finder_test.sv
